/* hdl/dqkd_pkg.sv */
package dqkd_pkg;

   localparam int unsigned PortWidth  = 8;
   localparam int unsigned KnobStates = 8;
   localparam int unsigned StateWidth = $clog2(KnobStates);

   typedef logic [PortWidth-1:0]  port_type;
   typedef logic [StateWidth-1:0] knob_state_type;
   typedef logic [1:0]            knob_value_type;
   typedef logic signed [1:0]     step_type;

   localparam step_type STEP_NONE = 2'sb00;
   localparam step_type STEP_CW   = 2'sb01;
   localparam step_type STEP_CCW  = 2'sb11;

   localparam knob_state_type ST_REST = 3'd0;
   localparam knob_state_type ST_WF3  = 3'd1;
   localparam knob_state_type ST_CW1  = 3'd2;
   localparam knob_state_type ST_CW2  = 3'd3;
   localparam knob_state_type ST_CW3  = 3'd4;
   localparam knob_state_type ST_CCW1 = 3'd5;
   localparam knob_state_type ST_CCW2 = 3'd6;
   localparam knob_state_type ST_CCW3 = 3'd7;

   // port bit positions
   localparam int unsigned RightButtonBit = 0;
   localparam int unsigned LeftButtonBit  = 1;
   localparam int unsigned RightKnobLsb   = 2;
   localparam int unsigned LeftKnobLsb    = 4;

   typedef struct packed {
      logic           ccw;
      logic           cw;
      knob_state_type next;
   } knob_entry_type;

   typedef knob_entry_type [KnobStates-1:0][3:0] knob_table_type;

   // rows are the old state, columns the new 2-bit knob value
   localparam knob_table_type KNOB_TABLE = '{
      '{ {1'b1, 1'b0, ST_REST}, {1'b0, 1'b0, ST_WF3},  {1'b0, 1'b0, ST_CCW3},
         {1'b0, 1'b0, ST_WF3} },
      '{ {1'b0, 1'b0, ST_REST}, {1'b0, 1'b0, ST_WF3},  {1'b0, 1'b0, ST_CCW3},
         {1'b0, 1'b0, ST_CCW2} },
      '{ {1'b0, 1'b0, ST_REST}, {1'b0, 1'b0, ST_CCW1}, {1'b0, 1'b0, ST_WF3},
         {1'b0, 1'b0, ST_CCW2} },
      '{ {1'b0, 1'b1, ST_REST}, {1'b0, 1'b0, ST_CW3},  {1'b0, 1'b0, ST_WF3},
         {1'b0, 1'b0, ST_WF3} },
      '{ {1'b0, 1'b0, ST_REST}, {1'b0, 1'b0, ST_CW3},  {1'b0, 1'b0, ST_WF3},
         {1'b0, 1'b0, ST_CW2} },
      '{ {1'b0, 1'b0, ST_REST}, {1'b0, 1'b0, ST_WF3},  {1'b0, 1'b0, ST_CW1},
         {1'b0, 1'b0, ST_CW2} },
      '{ {1'b0, 1'b0, ST_REST}, {1'b0, 1'b0, ST_WF3},  {1'b0, 1'b0, ST_WF3},
         {1'b0, 1'b0, ST_WF3} },
      '{ {1'b0, 1'b0, ST_REST}, {1'b0, 1'b0, ST_CCW1}, {1'b0, 1'b0, ST_CW1},
         {1'b0, 1'b0, ST_WF3} }
   };

   function automatic knob_entry_type knob_lookup(knob_state_type st, knob_value_type val);
      knob_lookup = KNOB_TABLE[st][val];
   endfunction

   function automatic step_type entry_step(knob_entry_type e);
      step_type s;
      if (e.ccw) begin
         s = STEP_CCW;
      end else if (e.cw) begin
         s = STEP_CW;
      end else begin
         s = STEP_NONE;
      end
      entry_step = s;
   endfunction

endpackage

/* hdl/dqkd_req_if.sv */
interface dqkd_req_if
   import dqkd_pkg::*;
();
   logic     valid;
   logic     ready;
   port_type port_bits;

   modport source (output valid, output port_bits, input ready);
   modport sink   (input valid, input port_bits, output ready);
endinterface

/* hdl/dqkd_rsp_if.sv */
interface dqkd_rsp_if
   import dqkd_pkg::*;
();
   logic     valid;
   logic     ready;
   step_type right_step;
   step_type left_step;
   logic     right_press;
   logic     left_press;

   modport source (output valid, output right_step, output left_step,
                   output right_press, output left_press, input ready);
   modport sink   (input valid, input right_step, input left_step,
                   input right_press, input left_press, output ready);
endinterface

/* hdl/dual_quadrature_knob_decoder_top.sv */
// Decodes two rotary knobs and two push buttons from one 8-bit port word per
// request: bit 0 right button, bit 1 left button, bits 2-3 right knob, bits 4-5
// left knob, bits 6-7 unused. Every request word gives exactly one response
// word with a signed step per knob (+1 clockwise detent, -1 counterclockwise,
// 0 none) and a press pulse per button (bit changed and is now high). The first
// word after reset is only stored and answers all zero. One word is taken per
// clock: the knob table lookup and edge compare sit between the state
// registers and the response register, and a new request is accepted whenever
// the response register is empty or being read in the same cycle.
module dual_quadrature_knob_decoder_top
   import dqkd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dqkd_req_if.sink   req_chan,
   dqkd_rsp_if.source rsp_chan
);

   port_type       prev_ff, prev_in;
   logic           primed_ff, primed_in;
   knob_state_type right_st_ff, right_st_in;
   knob_state_type left_st_ff, left_st_in;
   logic           rsp_valid_ff, rsp_valid_in;
   step_type       right_step_ff, right_step_in;
   step_type       left_step_ff, left_step_in;
   logic           right_press_ff, right_press_in;
   logic           left_press_ff, left_press_in;

   logic           accept;
   port_type       cur;
   port_type       chg;
   knob_entry_type right_entry;
   knob_entry_type left_entry;
   logic           right_moved;
   logic           left_moved;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign cur            = req_chan.port_bits;
   assign chg            = cur ^ prev_ff;

   assign right_entry = knob_lookup(right_st_ff, cur[RightKnobLsb +: 2]);
   assign left_entry  = knob_lookup(left_st_ff, cur[LeftKnobLsb +: 2]);
   assign right_moved = primed_ff && (chg[RightKnobLsb +: 2] != 2'b00);
   assign left_moved  = primed_ff && (chg[LeftKnobLsb +: 2] != 2'b00);

   always_comb begin
      prev_in        = prev_ff;
      primed_in      = primed_ff;
      right_st_in    = right_st_ff;
      left_st_in     = left_st_ff;
      right_step_in  = right_step_ff;
      left_step_in   = left_step_ff;
      right_press_in = right_press_ff;
      left_press_in  = left_press_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      if (accept) begin
         prev_in        = cur;
         primed_in      = 1'b1;
         rsp_valid_in   = 1'b1;
         right_press_in = primed_ff && chg[RightButtonBit] && cur[RightButtonBit];
         left_press_in  = primed_ff && chg[LeftButtonBit] && cur[LeftButtonBit];
         right_step_in  = STEP_NONE;
         left_step_in   = STEP_NONE;
         if (right_moved) begin
            right_st_in   = right_entry.next;
            right_step_in = entry_step(right_entry);
         end
         if (left_moved) begin
            left_st_in   = left_entry.next;
            left_step_in = entry_step(left_entry);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         primed_ff    <= 1'b0;
         right_st_ff  <= ST_REST;
         left_st_ff   <= ST_REST;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         primed_ff    <= primed_in;
         right_st_ff  <= right_st_in;
         left_st_ff   <= left_st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      right_step_ff  <= right_step_in;
      left_step_ff   <= left_step_in;
      right_press_ff <= right_press_in;
      left_press_ff  <= left_press_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.right_step  = right_step_ff;
   assign rsp_chan.left_step   = left_step_ff;
   assign rsp_chan.right_press = right_press_ff;
   assign rsp_chan.left_press  = left_press_ff;

endmodule
